[rtl/core/sbct_pkg.sv]
// Types and constants shared by the sorted block cache tag modules.
`default_nettype none
package sbct_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_FILL   = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_EVICTED   = 3'd3;
  localparam logic [2:0] ST_DROPPED   = 3'd4;
  localparam logic [2:0] ST_UPDATED   = 3'd5;
  localparam logic [2:0] ST_UPD_MISS  = 3'd6;

  localparam logic [15:0] HITS_MAX = 16'hFFFE;
  localparam logic [15:0] HITS_ALL = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  device_id;
    logic [7:0]  logical_device;
    logic [31:0] blk_addr;
    logic [31:0] run_first_lba;
    logic [31:0] run_last_lba;
    logic        parser_owned;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [15:0] hit_count;
  } out_word_t;

  typedef struct packed {
    logic [47:0] key;
    logic [15:0] hits;
    logic        parser;
    logic        dirty;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_UPDATE,
    CMD_INSERT,
    CMD_DELETE
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e   cmd;
    logic [47:0] key;
    logic [31:0] run_first;
    logic [31:0] run_last;
    logic [15:0] ins_hits;
    logic        ins_parser;
  } cell_ctl_t;

  typedef struct packed {
    logic        found;
    logic [15:0] mhits;
    logic        have;
    logic [15:0] chits;
    logic        cpar;
  } acc_t;

endpackage
`default_nettype wire

[rtl/core/sbct_cell.sv]
// One cell of the sorted entry chain with its stage of the scan pipeline.
`default_nettype none
module sbct_cell #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned INDEX   = 0,
  parameter int unsigned IDX_W   = 6,
  parameter int unsigned CNT_W   = 7
) (
  input  wire                     clk_i,
  input  sbct_pkg::cell_ctl_t     ctl_i,
  input  wire [CNT_W-1:0]         count_i,
  input  wire [IDX_W-1:0]         del_idx_i,
  input  wire [IDX_W-1:0]         ins_slot_i,
  input  sbct_pkg::entry_t        prev_ent_i,
  input  wire [IDX_W-1:0]         prev_slot_i,
  input  sbct_pkg::entry_t        next_ent_i,
  input  wire [IDX_W-1:0]         next_slot_i,
  output sbct_pkg::entry_t        ent_o,
  output logic [IDX_W-1:0]        slot_o,
  input  sbct_pkg::acc_t          acc_i,
  input  wire [IDX_W-1:0]         acc_mslot_i,
  input  wire [IDX_W-1:0]         acc_cidx_i,
  input  wire [IDX_W-1:0]         acc_cslot_i,
  output sbct_pkg::acc_t          acc_o,
  output logic [IDX_W-1:0]        acc_mslot_o,
  output logic [IDX_W-1:0]        acc_cidx_o,
  output logic [IDX_W-1:0]        acc_cslot_o
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  sbct_pkg::entry_t ent_q, ent_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  sbct_pkg::acc_t   acc_q, acc_d;
  logic [IDX_W-1:0] mslot_q, mslot_d, cidx_q, cidx_d, cslot_q, cslot_d;

  logic        valid, prev_valid, gt_self, gt_prev, match, prot;
  logic [31:0] lba;

  always_comb begin
    valid      = MY_CNT < count_i;
    prev_valid = (INDEX > 0) && (MY_CNT <= count_i);
    gt_self    = valid && (ent_q.key > ctl_i.key);
    gt_prev    = prev_valid && (prev_ent_i.key > ctl_i.key);
    match      = valid && (ent_q.key == ctl_i.key);
    lba        = ent_q.key[31:0];
    prot       = (lba >= ctl_i.run_first) && (lba <= ctl_i.run_last);
  end

  always_comb begin
    ent_d  = ent_q;
    slot_d = slot_q;
    case (ctl_i.cmd)
      sbct_pkg::CMD_UPDATE: begin
        if (match) begin
          ent_d.dirty = 1'b1;
          if (ent_q.hits < sbct_pkg::HITS_MAX) begin
            ent_d.hits = ent_q.hits + 16'd1;
          end
        end
      end
      sbct_pkg::CMD_INSERT: begin
        if (gt_prev) begin
          ent_d  = prev_ent_i;
          slot_d = prev_slot_i;
        end else if ((!valid || gt_self) && (INDEX == 0 || prev_valid)) begin
          ent_d.key    = ctl_i.key;
          ent_d.hits   = ctl_i.ins_hits;
          ent_d.parser = ctl_i.ins_parser;
          ent_d.dirty  = 1'b0;
          slot_d       = ins_slot_i;
        end
      end
      sbct_pkg::CMD_DELETE: begin
        if ((INDEX < ENTRIES - 1) && (MY_IDX >= del_idx_i)) begin
          ent_d  = next_ent_i;
          slot_d = next_slot_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    acc_d   = acc_i;
    mslot_d = acc_mslot_i;
    cidx_d  = acc_cidx_i;
    cslot_d = acc_cslot_i;
    if (valid) begin
      if (match) begin
        acc_d.found = 1'b1;
        acc_d.mhits = ent_q.hits;
        mslot_d     = slot_q;
      end
      if (!prot && (!acc_i.have || ent_q.hits < acc_i.chits ||
                    (acc_i.cpar && !ent_q.parser))) begin
        acc_d.have  = 1'b1;
        acc_d.chits = ent_q.hits;
        acc_d.cpar  = ent_q.parser;
        cidx_d      = MY_IDX;
        cslot_d     = slot_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    slot_q  <= slot_d;
    acc_q   <= acc_d;
    mslot_q <= mslot_d;
    cidx_q  <= cidx_d;
    cslot_q <= cslot_d;
  end

  assign ent_o       = ent_q;
  assign slot_o      = slot_q;
  assign acc_o       = acc_q;
  assign acc_mslot_o = mslot_q;
  assign acc_cidx_o  = cidx_q;
  assign acc_cslot_o = cslot_q;

endmodule
`default_nettype wire

[rtl/core/sorted_block_cache_tags.sv]
// Top level of the sorted block cache tag store with its control sequencer.
// The block keeps cache entries in key order in a row of cells, one entry per
// cell. A request word arrives on in_word_i under in_valid_i and is taken when
// in_stall_o is low; the result word leaves on out_word_o under out_valid_o
// and is held until a cycle with out_stall_i low. One request is handled at a
// time. Each request walks a scan token down the whole row, one cell per
// cycle, then passes a decide state, an insert state for a fill that evicts,
// and an output state. The result sits in an output register, so the next
// request may be taken while the receiver still stalls the last result. The
// register initial_hits is written through cfg_we_i and cfg_data_i; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset empties the cache, clears the output and sets initial_hits to one.
`default_nettype none
module sorted_block_cache_tags #(
  parameter int unsigned CACHE_ENTRIES = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [15:0]           cfg_data_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  sbct_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output sbct_pkg::out_word_t  out_word_o
);

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_INSERT,
    S_OUT
  } state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    scan_cnt_q;
  logic [CNT_W-1:0]    count_q;
  logic [15:0]         init_hits_q;
  sbct_pkg::in_word_t  req_q;
  sbct_pkg::out_word_t res_q, res_d;
  sbct_pkg::out_word_t out_word_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    vic_slot_q;

  sbct_pkg::cell_ctl_t ctl;
  logic [IDX_W-1:0]    del_idx, ins_slot;
  logic [15:0]         ih, upd_hits;
  logic                full, out_free;
  logic [CNT_W-1:0]    count_d;
  state_e              next_after_decide;

  sbct_pkg::entry_t    ent [CACHE_ENTRIES];
  logic [IDX_W-1:0]    slot [CACHE_ENTRIES];
  sbct_pkg::acc_t      acc [CACHE_ENTRIES];
  logic [IDX_W-1:0]    amslot [CACHE_ENTRIES];
  logic [IDX_W-1:0]    acidx [CACHE_ENTRIES];
  logic [IDX_W-1:0]    acslot [CACHE_ENTRIES];

  sbct_pkg::acc_t      fin;

  assign fin      = acc[CACHE_ENTRIES-1];
  assign ih       = (init_hits_q == sbct_pkg::HITS_ALL) ? sbct_pkg::HITS_MAX : init_hits_q;
  assign full     = count_q == FULL_CNT;
  assign out_free = !out_valid_q || !out_stall_i;
  assign upd_hits = (fin.mhits < sbct_pkg::HITS_MAX) ? fin.mhits + 16'd1 : fin.mhits;

  always_comb begin
    ctl.key        = {req_q.device_id, req_q.logical_device, req_q.blk_addr};
    ctl.run_first  = req_q.run_first_lba;
    ctl.run_last   = req_q.run_last_lba;
    ctl.ins_hits   = ih;
    ctl.ins_parser = req_q.parser_owned;
    ctl.cmd        = sbct_pkg::CMD_NONE;
    del_idx        = acidx[CACHE_ENTRIES-1];
    ins_slot       = count_q[IDX_W-1:0];
    res_d          = '0;
    count_d        = count_q;
    next_after_decide = S_OUT;
    case (state_q)
      S_DECIDE: begin
        if (req_q.operation == sbct_pkg::OP_UPDATE) begin
          if (fin.found) begin
            ctl.cmd = sbct_pkg::CMD_UPDATE;
            res_d   = '{sbct_pkg::ST_UPDATED, 6'(amslot[CACHE_ENTRIES-1]), upd_hits};
          end else begin
            res_d.status = sbct_pkg::ST_UPD_MISS;
          end
        end else if (fin.found) begin
          res_d = '{sbct_pkg::ST_HIT, 6'(amslot[CACHE_ENTRIES-1]), fin.mhits};
        end else if (req_q.operation != sbct_pkg::OP_FILL) begin
          res_d.status = sbct_pkg::ST_MISS;
        end else if (!full) begin
          ctl.cmd = sbct_pkg::CMD_INSERT;
          count_d = count_q + CNT_W'(1);
          res_d   = '{sbct_pkg::ST_INSERTED, 6'(count_q[IDX_W-1:0]), ih};
        end else if (!req_q.parser_owned || !fin.have) begin
          res_d.status = sbct_pkg::ST_DROPPED;
        end else begin
          ctl.cmd = sbct_pkg::CMD_DELETE;
          count_d = count_q - CNT_W'(1);
          res_d   = '{sbct_pkg::ST_EVICTED, 6'(acslot[CACHE_ENTRIES-1]), ih};
          next_after_decide = S_INSERT;
        end
      end
      S_INSERT: begin
        ctl.cmd  = sbct_pkg::CMD_INSERT;
        ins_slot = vic_slot_q;
        count_d  = count_q + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      count_q     <= '0;
      init_hits_q <= 16'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        init_hits_q <= cfg_data_i;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      count_q <= count_d;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_SCAN;
            scan_cnt_q <= '0;
          end
        end
        S_SCAN: begin
          scan_cnt_q <= scan_cnt_q + IDX_W'(1);
          if (scan_cnt_q == LAST_IDX) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= next_after_decide;
        end
        S_INSERT: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= in_word_i;
    end
    if (state_q == S_DECIDE) begin
      res_q      <= res_d;
      vic_slot_q <= acslot[CACHE_ENTRIES-1];
    end
    if (state_q == S_OUT && out_free) begin
      out_word_q <= res_q;
    end
  end

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    sbct_pkg::entry_t prev_ent, next_ent;
    logic [IDX_W-1:0] prev_slot, next_slot, in_mslot, in_cidx, in_cslot;
    sbct_pkg::acc_t   in_acc;

    if (i == 0) begin : g_head
      assign prev_ent  = '0;
      assign prev_slot = '0;
      assign in_acc    = '0;
      assign in_mslot  = '0;
      assign in_cidx   = '0;
      assign in_cslot  = '0;
    end else begin : g_body
      assign prev_ent  = ent[i-1];
      assign prev_slot = slot[i-1];
      assign in_acc    = acc[i-1];
      assign in_mslot  = amslot[i-1];
      assign in_cidx   = acidx[i-1];
      assign in_cslot  = acslot[i-1];
    end

    if (i == CACHE_ENTRIES - 1) begin : g_tail
      assign next_ent  = '0;
      assign next_slot = '0;
    end else begin : g_mid
      assign next_ent  = ent[i+1];
      assign next_slot = slot[i+1];
    end

    sbct_cell #(
      .ENTRIES(CACHE_ENTRIES),
      .INDEX  (i),
      .IDX_W  (IDX_W),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .count_i    (count_q),
      .del_idx_i  (del_idx),
      .ins_slot_i (ins_slot),
      .prev_ent_i (prev_ent),
      .prev_slot_i(prev_slot),
      .next_ent_i (next_ent),
      .next_slot_i(next_slot),
      .ent_o      (ent[i]),
      .slot_o     (slot[i]),
      .acc_i      (in_acc),
      .acc_mslot_i(in_mslot),
      .acc_cidx_i (in_cidx),
      .acc_cslot_i(in_cslot),
      .acc_o      (acc[i]),
      .acc_mslot_o(amslot[i]),
      .acc_cidx_o (acidx[i]),
      .acc_cslot_o(acslot[i])
    );
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire
